// ----- hw/rtl/cdg_pkg.sv -----
`timescale 1ns / 1ps
package cdg_pkg;

    // Configuration port
    localparam int CFG_BITS       = 7;
    localparam int CFG_INDEX_BITS = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ROWS_IN_USE = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLS_IN_USE = 4'd1;

    localparam int DIM_MIN   = 2;
    localparam int DIM_RESET = 10;

    // Operand slots carried with each job
    localparam int NUM_OPS     = 8;
    localparam int OP_PIX      = 0;  // incoming pixel, row r column c
    localparam int OP_ABOVE    = 1;  // row r-2 column c, or row r-1 on the second row
    localparam int OP_RIGHT    = 2;  // row r-1 column c+1, or itself on the last column
    localparam int OP_LEFT     = 3;  // row r-1 column c-1, or itself on the first column
    localparam int OP_PREV_PIX = 4;  // row r column c-1
    localparam int OP_PREV_MID = 5;  // row r-1 column c-1
    localparam int OP_LEFT2    = 6;  // row r column c-2, or c-1 on the second column
    localparam int OP_MID      = 7;  // row r-1 column c

    // Which results a job gives
    typedef struct packed {
        logic emit_last;   // final position of the frame
        logic emit_left;   // last-row position to the left
        logic emit_above;  // position above the pixel
    } job_ctrl_t;

    typedef enum logic [2:0] {
        KIND_ABOVE = 3'b001,
        KIND_LEFT  = 3'b010,
        KIND_LAST  = 3'b100
    } kind_t;

endpackage

// ----- hw/rtl/cdg_ram.sv -----
`timescale 1ns / 1ps
module cdg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/cdg_front.sv -----
`timescale 1ns / 1ps
module cdg_front #(
    parameter int MAX_DIM    = 64,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [cdg_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
    input  logic [cdg_pkg::CFG_BITS-1:0]                  cfg_data,
    input  logic                                          s_valid,
    output logic                                          s_ready,
    input  logic signed [PIXEL_BITS-1:0]                  s_pixel,
    output logic                                          job_valid,
    input  logic                                          job_ready,
    output cdg_pkg::job_ctrl_t                            job_ctrl,
    output logic [$clog2(MAX_DIM)-1:0]                    job_row,
    output logic [$clog2(MAX_DIM)-1:0]                    job_col,
    output logic [cdg_pkg::NUM_OPS-1:0][PIXEL_BITS-1:0]   job_ops
);

    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int CW      = cdg_pkg::CFG_BITS;
    localparam int CMP_W   = (IDX_W + 1 > CW) ? IDX_W + 1 : CW;
    localparam int DIM_CAP = (MAX_DIM < (1 << CW)) ? MAX_DIM : (1 << CW) - 1;
    localparam int DIM_RST = (MAX_DIM < cdg_pkg::DIM_RESET) ? MAX_DIM : cdg_pkg::DIM_RESET;

    localparam logic [CW-1:0] DIM_MAX_V = CW'(DIM_CAP);
    localparam logic [CW-1:0] DIM_MIN_V = CW'(cdg_pkg::DIM_MIN);
    localparam logic [CW-1:0] DIM_RST_V = CW'(DIM_RST);

    function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        r = v;
        if (v < DIM_MIN_V) begin
            r = DIM_MIN_V;
        end else if (v > DIM_MAX_V) begin
            r = DIM_MAX_V;
        end
        return r;
    endfunction

    logic [CW-1:0]    rows_reg;
    logic [CW-1:0]    cols_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;

    logic [PIXEL_BITS-1:0] prev_pix_reg;
    logic [PIXEL_BITS-1:0] prev2_pix_reg;
    logic [PIXEL_BITS-1:0] prev_mid_reg;

    logic                                        job_valid_reg;
    cdg_pkg::job_ctrl_t                          job_ctrl_reg;
    logic [IDX_W-1:0]                            job_row_reg;
    logic [IDX_W-1:0]                            job_col_reg;
    logic                                        last_col_reg;
    logic [cdg_pkg::NUM_OPS-1:0][PIXEL_BITS-1:0] ops_reg;

    logic                        accept;
    logic                        last_col;
    logic                        last_row;
    logic [IDX_W-1:0]            col_ahead;
    logic [2*PIXEL_BITS-1:0]     rd_data;
    logic [PIXEL_BITS-1:0]       mid;
    logic [PIXEL_BITS-1:0]       old;

    assign cfg_ready = 1'b1;
    assign s_ready   = !job_valid_reg || job_ready;
    assign accept    = s_valid && s_ready;

    assign last_col  = (CMP_W'(col_reg) + CMP_W'(1)) == CMP_W'(cols_reg);
    assign last_row  = (CMP_W'(row_reg) + CMP_W'(1)) == CMP_W'(rows_reg);
    assign col_ahead = last_col ? '0 : col_reg + IDX_W'(1);

    // Entry holds {older row, newer row} of one column
    assign mid = rd_data[PIXEL_BITS-1:0];
    assign old = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];

    // Read one column ahead while the current one is rewritten
    cdg_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_DIM)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data ({mid, s_pixel}),
        .rd_en   (accept),
        .rd_addr (col_ahead),
        .rd_data (rd_data)
    );

    // Configuration and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_RST_V;
            cols_reg <= DIM_RST_V;
            row_reg  <= '0;
            col_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cdg_pkg::REG_ROWS_IN_USE: begin
                    rows_reg <= clamp_dim(cfg_data);
                    row_reg  <= '0;
                    col_reg  <= '0;
                end
                cdg_pkg::REG_COLS_IN_USE: begin
                    cols_reg <= clamp_dim(cfg_data);
                    row_reg  <= '0;
                    col_reg  <= '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + IDX_W'(1);
            end else begin
                col_reg <= col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (accept) begin
            job_valid_reg <= 1'b1;
        end else if (job_ready) begin
            job_valid_reg <= 1'b0;
        end
    end

    // Classify the pixel and gather its neighbours
    always_ff @(posedge aclk) begin
        if (accept) begin
            job_ctrl_reg.emit_above <= row_reg != '0;
            job_ctrl_reg.emit_left  <= last_row && (col_reg != '0);
            job_ctrl_reg.emit_last  <= last_row && last_col;
            job_row_reg             <= row_reg;
            job_col_reg             <= col_reg;
            last_col_reg            <= last_col;

            ops_reg[cdg_pkg::OP_PIX]      <= s_pixel;
            ops_reg[cdg_pkg::OP_ABOVE]    <= (row_reg == IDX_W'(1)) ? mid : old;
            ops_reg[cdg_pkg::OP_RIGHT]    <= mid;
            ops_reg[cdg_pkg::OP_LEFT]     <= (col_reg == '0) ? mid : prev_mid_reg;
            ops_reg[cdg_pkg::OP_PREV_PIX] <= prev_pix_reg;
            ops_reg[cdg_pkg::OP_PREV_MID] <= prev_mid_reg;
            ops_reg[cdg_pkg::OP_LEFT2]    <= (col_reg == IDX_W'(1)) ? prev_pix_reg
                                                                    : prev2_pix_reg;
            ops_reg[cdg_pkg::OP_MID]      <= mid;

            prev2_pix_reg <= prev_pix_reg;
            prev_pix_reg  <= s_pixel;
            prev_mid_reg  <= mid;
        end
    end

    // Right neighbour: look-ahead read made on accept, or OP_MID on the last column
    always_comb begin
        job_ops = ops_reg;
        job_ops[cdg_pkg::OP_RIGHT] = last_col_reg ? ops_reg[cdg_pkg::OP_MID] : mid;
    end

    assign job_valid = job_valid_reg;
    assign job_ctrl  = job_ctrl_reg;
    assign job_row   = job_row_reg;
    assign job_col   = job_col_reg;

endmodule

// ----- hw/rtl/cdg_queue.sv -----
`timescale 1ns / 1ps
module cdg_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != (PW + 1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (PW + 1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (PW + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/cdg_back.sv -----
`timescale 1ns / 1ps
module cdg_back #(
    parameter int MAX_DIM    = 64,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          job_valid,
    output logic                                          job_ready,
    input  cdg_pkg::job_ctrl_t                            job_ctrl,
    input  logic [$clog2(MAX_DIM)-1:0]                    job_row,
    input  logic [$clog2(MAX_DIM)-1:0]                    job_col,
    input  logic [cdg_pkg::NUM_OPS-1:0][PIXEL_BITS-1:0]   job_ops,
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic [$clog2(MAX_DIM)-1:0]                    m_row_index,
    output logic [$clog2(MAX_DIM)-1:0]                    m_col_index,
    output logic signed [PIXEL_BITS-1:0]                  m_row_gradient,
    output logic signed [PIXEL_BITS-1:0]                  m_col_gradient,
    output logic                                          m_frame_last
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DW    = PIXEL_BITS + 1;

    // (x - y) / 2, truncated toward zero
    function automatic logic [PIXEL_BITS-1:0] half_diff(input logic [PIXEL_BITS-1:0] x,
                                                         input logic [PIXEL_BITS-1:0] y);
        logic signed [DW-1:0] d;
        logic signed [DW-1:0] s;
        logic signed [DW-1:0] h;
        d = $signed({x[PIXEL_BITS-1], x}) - $signed({y[PIXEL_BITS-1], y});
        s = d + DW'(d[DW-1]);
        h = s >>> 1;
        return h[PIXEL_BITS-1:0];
    endfunction

    cdg_pkg::job_ctrl_t done_reg;
    cdg_pkg::job_ctrl_t done_next;
    cdg_pkg::kind_t     kind;

    logic [2:0]            pend;
    logic [2:0]            rest;
    logic                  out_free;
    logic                  emit;
    logic [PIXEL_BITS-1:0] row_min;
    logic [PIXEL_BITS-1:0] row_sub;
    logic [PIXEL_BITS-1:0] col_min;
    logic [PIXEL_BITS-1:0] col_sub;
    logic [IDX_W-1:0]      sel_row;
    logic [IDX_W-1:0]      sel_col;
    logic                  sel_last;

    logic                  m_valid_reg;
    logic [IDX_W-1:0]      row_index_reg;
    logic [IDX_W-1:0]      col_index_reg;
    logic [PIXEL_BITS-1:0] row_grad_reg;
    logic [PIXEL_BITS-1:0] col_grad_reg;
    logic                  frame_last_reg;

    assign pend     = job_ctrl & ~done_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Oldest outstanding result of the job first
    always_comb begin
        kind = cdg_pkg::KIND_LAST;
        if (pend[1]) begin
            kind = cdg_pkg::KIND_LEFT;
        end
        if (pend[0]) begin
            kind = cdg_pkg::KIND_ABOVE;
        end
    end

    assign rest      = pend & ~kind;
    assign emit      = job_valid && (pend != '0) && out_free;
    assign job_ready = job_valid && ((pend == '0) || (out_free && (rest == '0)));

    always_comb begin
        done_next = done_reg;
        if (job_ready) begin
            done_next = '0;
        end else if (emit) begin
            done_next = done_reg | kind;
        end
    end

    always_comb begin
        unique case (kind)
            cdg_pkg::KIND_ABOVE: begin
                row_min  = job_ops[cdg_pkg::OP_PIX];
                row_sub  = job_ops[cdg_pkg::OP_ABOVE];
                col_min  = job_ops[cdg_pkg::OP_RIGHT];
                col_sub  = job_ops[cdg_pkg::OP_LEFT];
                sel_row  = job_row - IDX_W'(1);
                sel_col  = job_col;
                sel_last = 1'b0;
            end
            cdg_pkg::KIND_LEFT: begin
                row_min  = job_ops[cdg_pkg::OP_PREV_PIX];
                row_sub  = job_ops[cdg_pkg::OP_PREV_MID];
                col_min  = job_ops[cdg_pkg::OP_PIX];
                col_sub  = job_ops[cdg_pkg::OP_LEFT2];
                sel_row  = job_row;
                sel_col  = job_col - IDX_W'(1);
                sel_last = 1'b0;
            end
            cdg_pkg::KIND_LAST: begin
                row_min  = job_ops[cdg_pkg::OP_PIX];
                row_sub  = job_ops[cdg_pkg::OP_MID];
                col_min  = job_ops[cdg_pkg::OP_PIX];
                col_sub  = job_ops[cdg_pkg::OP_PREV_PIX];
                sel_row  = job_row;
                sel_col  = job_col;
                sel_last = 1'b1;
            end
            default: begin
                row_min  = '0;
                row_sub  = '0;
                col_min  = '0;
                col_sub  = '0;
                sel_row  = '0;
                sel_col  = '0;
                sel_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            row_index_reg  <= sel_row;
            col_index_reg  <= sel_col;
            row_grad_reg   <= half_diff(row_min, row_sub);
            col_grad_reg   <= half_diff(col_min, col_sub);
            frame_last_reg <= sel_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_row_index    = row_index_reg;
    assign m_col_index    = col_index_reg;
    assign m_row_gradient = row_grad_reg;
    assign m_col_gradient = col_grad_reg;
    assign m_frame_last   = frame_last_reg;

endmodule

// ----- hw/rtl/central_difference_gradient_unit.sv -----
// Path: a pixel goes as a job through the front's job register and the two-entry queue to the
//   output register; results trail the pixels by one row, and by one column on the last row.
// Throughput: one pixel per cycle while m_ready is set, on all rows but the last, where each
//   pixel after the first gives two results through the single output register; the frame's
//   final pixel gives three.
// Reset: synchronous, active-low aresetn empties the pipeline, zeroes the position counters and
//   sets both frame dimensions to 10 (MAX_DIM if less). The line store is not cleared.
`timescale 1ns / 1ps
module central_difference_gradient_unit #(
    parameter int MAX_DIM    = 64,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cdg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [cdg_pkg::CFG_BITS-1:0]          cfg_data,
    // pixel stream in
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [PIXEL_BITS-1:0]          s_pixel,
    // gradient results out
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [$clog2(MAX_DIM)-1:0]            m_row_index,
    output logic [$clog2(MAX_DIM)-1:0]            m_col_index,
    output logic signed [PIXEL_BITS-1:0]          m_row_gradient,
    output logic signed [PIXEL_BITS-1:0]          m_col_gradient,
    output logic                                  m_frame_last
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int OPS_W  = cdg_pkg::NUM_OPS * PIXEL_BITS;
    localparam int CTRL_W = $bits(cdg_pkg::job_ctrl_t);
    localparam int JOB_W  = CTRL_W + 2 * IDX_W + OPS_W;

    // Front to queue
    logic                                        f_valid;
    logic                                        f_ready;
    cdg_pkg::job_ctrl_t                          f_ctrl;
    logic [IDX_W-1:0]                            f_row;
    logic [IDX_W-1:0]                            f_col;
    logic [cdg_pkg::NUM_OPS-1:0][PIXEL_BITS-1:0] f_ops;

    // Queue to back
    logic                                        b_valid;
    logic                                        b_ready;
    cdg_pkg::job_ctrl_t                          b_ctrl;
    logic [IDX_W-1:0]                            b_row;
    logic [IDX_W-1:0]                            b_col;
    logic [cdg_pkg::NUM_OPS-1:0][PIXEL_BITS-1:0] b_ops;

    logic [JOB_W-1:0] push_word;
    logic [JOB_W-1:0] pop_word;

    // Front: take pixels, keep the line store and position, decide which results
    // each pixel owes and gather the neighbours they need.
    cdg_front #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job_ctrl  (f_ctrl),
        .job_row   (f_row),
        .job_col   (f_col),
        .job_ops   (f_ops)
    );

    // Two-entry queue: lets the front keep taking pixels while the back
    // works through the double results of the last row.
    assign push_word = {f_ctrl, f_row, f_col, f_ops};

    cdg_queue #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (push_word),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (pop_word)
    );

    assign {b_ctrl, b_row, b_col, b_ops} = pop_word;

    // Back: one result per cycle into the output register while m_ready allows, in job order;
    // jobs that owe nothing (first row) are dropped at once.
    cdg_back #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_valid      (b_valid),
        .job_ready      (b_ready),
        .job_ctrl       (b_ctrl),
        .job_row        (b_row),
        .job_col        (b_col),
        .job_ops        (b_ops),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_index    (m_row_index),
        .m_col_index    (m_col_index),
        .m_row_gradient (m_row_gradient),
        .m_col_gradient (m_col_gradient),
        .m_frame_last   (m_frame_last)
    );

endmodule

// ----- hw/rtl/cdg_checker.sv -----
`timescale 1ns / 1ps
module cdg_checker #(
    parameter int MAX_DIM    = 64,
    parameter int PIXEL_BITS = 16
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [$clog2(MAX_DIM)-1:0]            m_row_index,
    input logic [$clog2(MAX_DIM)-1:0]            m_col_index,
    input logic signed [PIXEL_BITS-1:0]          m_row_gradient,
    input logic signed [PIXEL_BITS-1:0]          m_col_gradient,
    input logic                                  m_frame_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_index) && $stable(m_col_index)
            && $stable(m_row_gradient) && $stable(m_col_gradient) && $stable(m_frame_last))
        else $error("result changed while stalled");

    // Reset empties the output and opens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output or input side not idle after reset");

    // The frame ends at the bottom-right corner; this asserts that it is never flagged on the first row or column
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_row_index != '0 && m_col_index != '0)
        else $error("frame end flagged away from the last position");

endmodule

bind central_difference_gradient_unit cdg_checker #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
) u_cdg_checker (.*);
